>>> rtl/fcrbd_pkg.sv
// Package: shared types and constants for the frequent-character run decoder.
`default_nettype none

package fcrbd_pkg;

    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 3;
    localparam int BITS_W     = 4;
    localparam int TABLE_W    = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int TABLE_SIZE = 16;

    localparam logic [IDX_W-1:0]     END_INDEX   = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_TBL_LO  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TBL_HI  = 1'b1;
    localparam logic [BITS_W-1:0]    LIT_BITS    = 4'd8;
    localparam logic [BITS_W-1:0]    IDX_BITS    = 4'd4;
    localparam logic [BITS_W-1:0]    CNT_BITS    = 4'd3;

    typedef enum logic [2:0] {
        PH_PREFIX1,
        PH_PREFIX2,
        PH_LITERAL,
        PH_SINGLE,
        PH_COUNT,
        PH_RUNIDX
    } phase_t;

endpackage

`default_nettype wire

>>> rtl/frequent_char_run_bit_decoder.sv
// Top level: bit-serial decoder of literals, table characters and table runs.
`default_nettype none

// Takes one compressed stream bit per cycle on the input channel if in_ready
// is high, field bits shifted into an 8-bit gather register MSB first.
// Codeword 1+8 bits gives a literal byte, 00+4 bits a table character (index
// 15: end of stream, reported once with stream_end set and out_char zero),
// 01+3+4 bits a run of 1 to 8 copies of a table character. Each character
// leaves through a single output register, one per cycle while out_ready is
// high; a run holds in_ready low until its last character transfers, when
// the next bit is taken. After the end marker, bits are accepted and dropped
// until reset. The 16-entry table is two 64-bit registers written through
// cfg_we; the user must write them only while the block is idle, unenforced.
module frequent_char_run_bit_decoder (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [fcrbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [fcrbd_pkg::TABLE_W-1:0]     cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              code_bit,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [fcrbd_pkg::CHAR_W-1:0]     out_char,
    output logic                             run_last,
    output logic                             stream_end
);
    import fcrbd_pkg::*;

    logic [TABLE_W-1:0]   table_low_reg;
    logic [TABLE_W-1:0]   table_high_reg;
    phase_t               phase_reg, phase_next;
    logic [BITS_W-1:0]    bits_left_reg, bits_left_next;
    logic [CHAR_W-1:0]    gather_reg, gather_next;
    logic [CNT_W-1:0]     rep_reg, rep_next;
    logic                 finished_reg, finished_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 run_last_reg, run_last_next;
    logic                 stream_end_reg, stream_end_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;

    logic [2*TABLE_W-1:0] tbl;
    logic [CHAR_W-1:0]    g_shift;
    logic [CHAR_W-1:0]    tbl_char;
    logic [BITS_W-1:0]    bits_dec;
    logic                 in_fire;
    logic                 out_fire;

    assign tbl      = {table_high_reg, table_low_reg};
    assign g_shift  = {gather_reg[CHAR_W-2:0], code_bit};
    assign tbl_char = tbl[{g_shift[IDX_W-1:0], 3'b000} +: CHAR_W];
    assign bits_dec = bits_left_reg - 1'b1;

    assign in_ready   = !out_valid_reg || (out_ready && (rem_reg == '0));
    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid_reg && out_ready;
    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_low_reg  <= '0;
            table_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TBL_LO: table_low_reg  <= cfg_data;
                CFG_TBL_HI: table_high_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PREFIX1;
            bits_left_reg  <= '0;
            gather_reg     <= '0;
            rep_reg        <= '0;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rem_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bits_left_reg  <= bits_left_next;
            gather_reg     <= gather_next;
            rep_reg        <= rep_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg   <= out_char_next;
        run_last_reg   <= run_last_next;
        stream_end_reg <= stream_end_next;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bits_left_next  = bits_left_reg;
        gather_next     = gather_reg;
        rep_next        = rep_reg;
        finished_next   = finished_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        run_last_next   = run_last_reg;
        stream_end_next = stream_end_reg;
        rem_next        = rem_reg;

        // drain the output register, stepping through a run
        if (out_fire)
        begin
            if (rem_reg != '0)
            begin
                rem_next      = rem_reg - 1'b1;
                run_last_next = (rem_reg == CNT_W'(1));
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (in_fire && !finished_reg)
        begin
            case (phase_reg)
                PH_PREFIX2:
                begin
                    gather_next = '0;
                    if (code_bit)
                    begin
                        phase_next     = PH_COUNT;
                        bits_left_next = CNT_BITS;
                    end
                    else
                    begin
                        phase_next     = PH_SINGLE;
                        bits_left_next = IDX_BITS;
                    end
                end
                PH_LITERAL, PH_SINGLE, PH_COUNT, PH_RUNIDX:
                begin
                    if (bits_dec != '0)
                    begin
                        gather_next    = g_shift;
                        bits_left_next = bits_dec;
                    end
                    else
                    begin
                        gather_next    = '0;
                        bits_left_next = '0;
                        phase_next     = PH_PREFIX1;
                        case (phase_reg)
                            PH_LITERAL:
                            begin
                                out_valid_next  = 1'b1;
                                out_char_next   = g_shift;
                                run_last_next   = 1'b1;
                                stream_end_next = 1'b0;
                                rem_next        = '0;
                            end
                            PH_SINGLE:
                            begin
                                out_valid_next  = 1'b1;
                                run_last_next   = 1'b1;
                                rem_next        = '0;
                                if (g_shift[IDX_W-1:0] == END_INDEX)
                                begin
                                    out_char_next   = '0;
                                    stream_end_next = 1'b1;
                                    finished_next   = 1'b1;
                                end
                                else
                                begin
                                    out_char_next   = tbl_char;
                                    stream_end_next = 1'b0;
                                end
                            end
                            PH_COUNT:
                            begin
                                rep_next       = g_shift[CNT_W-1:0];
                                phase_next     = PH_RUNIDX;
                                bits_left_next = IDX_BITS;
                            end
                            default:
                            begin
                                out_valid_next  = 1'b1;
                                out_char_next   = tbl_char;
                                run_last_next   = (rep_reg == '0);
                                stream_end_next = 1'b0;
                                rem_next        = rep_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    gather_next    = '0;
                    if (code_bit)
                    begin
                        phase_next     = PH_LITERAL;
                        bits_left_next = LIT_BITS;
                    end
                    else
                    begin
                        phase_next     = PH_PREFIX2;
                        bits_left_next = '0;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/fcrbd_checker.sv
// Checker: port-level assertions for the frequent-character run decoder.
`default_nettype none

module fcrbd_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire [fcrbd_pkg::CHAR_W-1:0]      out_char,
    input wire                              run_last,
    input wire                              stream_end
);
    import fcrbd_pkg::*;

    logic seen_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_end_reg <= 1'b0;
        else if (out_valid && out_ready && stream_end)
            seen_end_reg <= 1'b1;
    end

    // held result stays put until transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char)
            && $stable(run_last) && $stable(stream_end))
        else $error("output changed while stalled");

    // end report carries no character and has run_last set
    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> out_char == '0 && run_last)
        else $error("bad end-of-stream result");

    // nothing after the end report
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        seen_end_reg |-> !out_valid)
        else $error("result after end of stream");

    // a bit is taken only when the output slot frees up
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || (out_ready && run_last))
        else $error("input taken while results pending");

endmodule

bind frequent_char_run_bit_decoder fcrbd_checker u_fcrbd_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Testbench for the frequent-character run bit decoder: random and directed bitstreams.
`timescale 1ns / 100ps

module tb;

    import fcrbd_pkg::*;

    localparam int STREAM_BITS  = 304;
    localparam int TAIL_BITS    = 20;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              fin;
    } dec_char_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TABLE_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 code_bit;
    logic                 out_valid;
    logic                 out_ready;
    logic [CHAR_W-1:0]    out_char;
    logic                 run_last;
    logic                 stream_end;

    frequent_char_run_bit_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_bit   (code_bit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    // stimulus and scoreboard state
    logic      pending_bits[$];
    logic      stream_bits[$];
    dec_char_t expected_chars[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        rst_done      = 1'b0;
    bit        in_fire       = 1'b0;
    int        errors        = 0;
    int        stall_cycles  = 0;

    // decoder shadow state
    logic [TABLE_W-1:0] tbl_lo     = '0;
    logic [TABLE_W-1:0] tbl_hi     = '0;
    phase_t             dec_phase  = PH_PREFIX1;
    logic [BITS_W-1:0]  bits_left  = '0;
    logic [CHAR_W-1:0]  gathered   = '0;
    logic [3:0]         run_len    = '0;
    bit                 stream_done = 1'b0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [CHAR_W-1:0] table_char(input logic [IDX_W-1:0] idx);
        logic [2*TABLE_W-1:0] tbl;
        tbl = {tbl_hi, tbl_lo};
        return tbl[idx*CHAR_W +: CHAR_W];
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last,
                             input logic fin);
        dec_char_t e;
        e.ch   = ch;
        e.last = last;
        e.fin  = fin;
        expected_chars.push_back(e);
    endtask

    task automatic start_field(input phase_t ph, input logic [BITS_W-1:0] nbits);
        dec_phase = ph;
        bits_left = nbits;
        gathered  = '0;
    endtask

    task automatic decode_bit(input logic b);
        logic [CHAR_W-1:0] ch;
        int                n;
        if (stream_done)
            return;
        case (dec_phase)
            PH_PREFIX2:
            begin
                if (b)
                    start_field(PH_COUNT, CNT_BITS);
                else
                    start_field(PH_SINGLE, IDX_BITS);
                return;
            end
            PH_LITERAL, PH_SINGLE, PH_COUNT, PH_RUNIDX: ;
            default:
            begin
                if (b)
                    start_field(PH_LITERAL, LIT_BITS);
                else
                    start_field(PH_PREFIX2, '0);
                return;
            end
        endcase
        gathered = {gathered[CHAR_W-2:0], b};
        if (bits_left != 0)
            bits_left = bits_left - 1'b1;
        if (bits_left != 0)
            return;
        case (dec_phase)
            PH_LITERAL:
            begin
                push_char(gathered, 1'b1, 1'b0);
                start_field(PH_PREFIX1, '0);
            end
            PH_SINGLE:
            begin
                if (gathered[IDX_W-1:0] == END_INDEX)
                begin
                    push_char('0, 1'b1, 1'b1);
                    stream_done = 1'b1;
                end
                else
                begin
                    push_char(table_char(gathered[IDX_W-1:0]), 1'b1, 1'b0);
                end
                start_field(PH_PREFIX1, '0);
            end
            PH_COUNT:
            begin
                run_len = {1'b0, gathered[CNT_W-1:0]} + 4'd1;
                start_field(PH_RUNIDX, IDX_BITS);
            end
            default:
            begin
                ch = table_char(gathered[IDX_W-1:0]);
                n  = (run_len == 0 || run_len > 8) ? 8 : int'(run_len);
                for (int i = 0; i < n; i++)
                    push_char(ch, (i == n - 1), 1'b0);
                start_field(PH_PREFIX1, '0);
            end
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_done)
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_bits.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    code_bit <= pending_bits.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        dec_char_t e;
        in_fire <= in_valid && in_ready;
        if (cfg_we)
        begin
            if (cfg_index == CFG_TBL_LO)
                tbl_lo = cfg_data;
            else
                tbl_hi = cfg_data;
        end
        if (in_valid && in_ready)
            decode_bit(code_bit);
        if (out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected transfer, got char %02h last %0b end %0b",
                         $time, out_char, run_last, stream_end);
                errors++;
            end
            else
            begin
                e = expected_chars.pop_front();
                if (out_char !== e.ch)
                begin
                    $display("%0t: out_char expected %02h, got %02h", $time, e.ch, out_char);
                    errors++;
                end
                if (run_last !== e.last)
                begin
                    $display("%0t: run_last expected %0b, got %0b", $time, e.last, run_last);
                    errors++;
                end
                if (stream_end !== e.fin)
                begin
                    $display("%0t: stream_end expected %0b, got %0b",
                             $time, e.fin, stream_end);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_table(input logic [CFG_IDX_W-1:0] idx,
                               input logic [TABLE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_field(ref logic q[$], input logic [7:0] value, input int width);
        for (int i = width - 1; i >= 0; i--)
            q.push_back(value[i]);
    endtask

    task automatic wait_drained();
        while (pending_bits.size() > 0 || in_valid || expected_chars.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_slice(input int first, input int count);
        for (int i = first; i < first + count; i++)
            pending_bits.push_back(stream_bits[i]);
    endtask

    initial
    begin
        int kind;
        int third;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        code_bit  = 1'b0;
        out_ready = 1'b0;

        // random codeword stream, never the end marker
        while (stream_bits.size() < STREAM_BITS)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                stream_bits.push_back(1'b1);
                queue_field(stream_bits, 8'($urandom), 8);
            end
            else if (kind < 55)
            begin
                queue_field(stream_bits, 8'b00, 2);
                queue_field(stream_bits, 8'($urandom_range(14)), 4);
            end
            else
            begin
                queue_field(stream_bits, 8'b01, 2);
                queue_field(stream_bits, 8'($urandom_range(7)), 3);
                queue_field(stream_bits, 8'($urandom_range(15)), 4);
            end
        end
        third = stream_bits.size() / 3;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n    <= 1'b1;
        rst_done <= 1'b1;

        write_table(CFG_TBL_LO, '0);
        write_table(CFG_TBL_HI, '1);

        // directed: literal FF, single index 0, run of 8 from index 15,
        // then a run left open across a table rewrite
        send_idle_pct = 23;
        recv_idle_pct = 52;
        queue_field(pending_bits, 8'b1, 1);
        queue_field(pending_bits, 8'hFF, 8);
        queue_field(pending_bits, 8'b00, 2);
        queue_field(pending_bits, 8'h0, 4);
        queue_field(pending_bits, 8'b01, 2);
        queue_field(pending_bits, 8'h7, 3);
        queue_field(pending_bits, 8'hF, 4);
        queue_field(pending_bits, 8'b01, 2);
        queue_field(pending_bits, 8'h2, 3);
        wait_drained();

        write_table(CFG_TBL_LO, '1);
        write_table(CFG_TBL_HI, '0);
        queue_field(pending_bits, 8'h7, 4);
        send_slice(0, third);
        wait_drained();

        write_table(CFG_TBL_LO, {$urandom, $urandom});
        write_table(CFG_TBL_HI, {$urandom, $urandom});
        send_idle_pct = 52;
        recv_idle_pct = 23;
        send_slice(third, third);
        wait_drained();

        write_table(CFG_TBL_HI, {$urandom, $urandom});
        write_table(CFG_TBL_LO, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_slice(2 * third, stream_bits.size() - 2 * third);

        // end marker, then bits that must be dropped
        queue_field(pending_bits, 8'b00, 2);
        queue_field(pending_bits, 8'(END_INDEX), 4);
        for (int i = 0; i < TAIL_BITS; i++)
            pending_bits.push_back(1'($urandom));
        wait_drained();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
